[hdl/modular_arithmetic_unit_core_defines.svh]
// Assertion macros shared by the checker of the modular arithmetic unit
`ifndef MODULAR_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define MAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset
`define MAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset
`define MAU_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/mau_pkg.sv]
// Shared types and constants of the modular arithmetic unit
`timescale 1ns / 1ps
package mau_pkg;

  localparam int unsigned FW = 31;
  localparam logic [FW-1:0] MODULUS_RESET = 31'd1000000007;

  typedef enum logic [2:0] {
    F_ADD = 3'd0, F_SUB = 3'd1, F_MUL = 3'd2, F_DIV = 3'd3,
    F_POW = 3'd4, F_INV = 3'd5, F_NEG = 3'd6, F_RED = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    SRC_LHS = 2'd0, SRC_RHS = 2'd1, SRC_RAW = 2'd2, SRC_PROD = 2'd3
  } src_t;

  typedef enum logic [1:0] {
    MS_A_B = 2'd0, MS_ACC_SQ = 2'd1, MS_SQ_SQ = 2'd2, MS_A_ACC = 2'd3
  } msel_t;

  typedef enum logic [2:0] {
    DST_A = 3'd0, DST_B = 3'd1, DST_ACC = 3'd2, DST_SQ = 3'd3,
    DST_RES = 3'd4, DST_RAW = 3'd5
  } dest_t;

  typedef struct packed {
    logic  load;
    logic  start;
    src_t  src;
    msel_t msel;
    dest_t dest;
    logic  simple;
    logic  pow_init;
    logic  e_shift;
    logic  res_acc;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic  done;
    logic  m_small;
    func_t func;
    logic  e_zero;
    logic  e_lsb;
    logic  out_full;
  } status_t;

endpackage

[hdl/mau_in_if.sv]
// Request channel of the modular arithmetic unit
`timescale 1ns / 1ps
interface mau_in_if #(parameter int EXP_BITS = 63);
  logic                valid;
  logic                ready;
  logic [2:0]          func;
  logic [30:0]         lhs;
  logic [30:0]         rhs;
  logic [EXP_BITS-1:0] exponent;
  logic signed [63:0]  raw_value;
  modport source (output valid, func, lhs, rhs, exponent, raw_value, input ready);
  modport sink (input valid, func, lhs, rhs, exponent, raw_value, output ready);
endinterface

[hdl/mau_out_if.sv]
// Result channel of the modular arithmetic unit
`timescale 1ns / 1ps
interface mau_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] result;
  logic        equal;
  logic        less;
  modport source (output valid, result, equal, less, input ready);
  modport sink (input valid, result, equal, less, output ready);
endinterface

[hdl/mau_datapath.sv]
// Datapath: operand registers, multiplier, bit-serial reducer, output register
`timescale 1ns / 1ps
module mau_datapath #(
  parameter int EXP_BITS = 63
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mau_pkg::FW-1:0]      cfg_wdata,
  input  mau_pkg::cmd_t               cmd,
  output mau_pkg::status_t            sts,
  input  logic [2:0]                  in_func,
  input  logic [30:0]                 in_lhs,
  input  logic [30:0]                 in_rhs,
  input  logic [EXP_BITS-1:0]         in_exponent,
  input  logic signed [63:0]          in_raw_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [30:0]                 out_result,
  output logic                        out_equal,
  output logic                        out_less
);

  logic [30:0]         modulus;
  mau_pkg::func_t      func;
  logic [30:0]         rhs;
  logic [EXP_BITS-1:0] expo, e;
  logic [63:0]         mag_in;
  logic                neg, eq_f, lt_f;
  logic [30:0]         a, b, acc, sq, res;
  logic [61:0]         prod;
  logic [63:0]         shreg;
  logic [30:0]         rem;
  logic [5:0]          cnt;
  logic                busy, pend, done;
  mau_pkg::dest_t      dest;
  logic [30:0]         mx, my;
  logic [31:0]         t, tm;
  logic [30:0]         r_new;
  logic [31:0]         sum, sum_m;
  logic [31:0]         m_minus2;
  logic [30:0]         simple_r;

  // Hold the modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mau_pkg::MODULUS_RESET;
    end else if (cfg_we) begin
      modulus <= cfg_wdata;
    end
  end

  // Select multiplier operands
  always_comb begin
    case (cmd.msel)
      mau_pkg::MS_A_B:    begin mx = a;   my = b;   end
      mau_pkg::MS_ACC_SQ: begin mx = acc; my = sq;  end
      mau_pkg::MS_SQ_SQ:  begin mx = sq;  my = sq;  end
      default:            begin mx = a;   my = acc; end
    endcase
  end

  // Magnitude of the signed value, taken straight from the request
  assign mag_in = in_raw_value[63] ? (64'd0 - 64'(in_raw_value)) : 64'(in_raw_value);

  // One reducer step: shift in the next bit, subtract modulus at most once
  assign t     = {rem, shreg[63]};
  assign tm    = t - {1'b0, modulus};
  assign r_new = (t >= {1'b0, modulus}) ? tm[30:0] : t[30:0];

  // Results of the add, subtract and negate operations
  assign sum      = {1'b0, a} + {1'b0, b};
  assign sum_m    = sum - {1'b0, modulus};
  assign m_minus2 = {1'b0, modulus} - 32'd2;
  always_comb begin
    case (func)
      mau_pkg::F_ADD: simple_r = (sum >= {1'b0, modulus}) ? sum_m[30:0] : sum[30:0];
      mau_pkg::F_SUB: simple_r = (a >= b) ? (a - b) : (a + modulus - b);
      default:        simple_r = (a == '0) ? '0 : (modulus - a);
    endcase
  end

  // Capture the request and run the reducer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        dest <= cmd.dest;
        rem  <= '0;
        cnt  <= 6'd63;
        case (cmd.src)
          mau_pkg::SRC_LHS: begin shreg <= {33'd0, in_lhs}; busy <= 1'b1; end
          mau_pkg::SRC_RHS: begin shreg <= {33'd0, rhs}; busy <= 1'b1; end
          mau_pkg::SRC_RAW: begin shreg <= mag_in; busy <= 1'b1; end
          default: begin
            prod <= 62'(mx) * 62'(my);
            pend <= 1'b1;
          end
        endcase
      end else if (pend) begin
        shreg <= {2'b00, prod};
        pend  <= 1'b0;
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= r_new;
        shreg <= {shreg[62:0], 1'b0};
        cnt   <= cnt - 6'd1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Write operand and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func <= mau_pkg::func_t'(in_func);
      rhs  <= in_rhs;
      expo <= in_exponent;
      neg  <= in_raw_value[63];
      eq_f <= (in_lhs == in_rhs);
      lt_f <= (in_lhs < in_rhs);
      res  <= '0;
    end
    if (busy && !pend && cnt == '0) begin
      case (dest)
        mau_pkg::DST_A:   a   <= r_new;
        mau_pkg::DST_B:   b   <= r_new;
        mau_pkg::DST_ACC: acc <= r_new;
        mau_pkg::DST_SQ:  sq  <= r_new;
        mau_pkg::DST_RES: res <= r_new;
        default: res <= (neg && r_new != '0) ? (modulus - r_new) : r_new;
      endcase
    end
    if (cmd.simple) begin
      res <= simple_r;
    end
    if (cmd.pow_init) begin
      sq  <= (func == mau_pkg::F_DIV) ? b : a;
      acc <= 31'd1;
      e   <= (func == mau_pkg::F_POW) ? expo : EXP_BITS'({32'd0, m_minus2});
    end
    if (cmd.e_shift) begin
      e <= e >> 1;
    end
    if (cmd.res_acc) begin
      res <= acc;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_result <= res;
      out_equal  <= eq_f;
      out_less   <= lt_f;
    end
  end

  assign sts.done     = done;
  assign sts.m_small  = (modulus < 31'd2);
  assign sts.func     = func;
  assign sts.e_zero   = (e == '0);
  assign sts.e_lsb    = e[0];
  assign sts.out_full = out_valid;

endmodule

[hdl/mau_ctrl.sv]
// Controller: sequences reductions, multiplies and the power loop
`timescale 1ns / 1ps
module mau_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_func,
  input  logic             out_ready,
  input  mau_pkg::status_t sts,
  output mau_pkg::cmd_t    cmd
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RDA  = 10'b0000000010,
    S_RDB  = 10'b0000000100,
    S_DISP = 10'b0000001000,
    S_PCHK = 10'b0000010000,
    S_PACC = 10'b0000100000,
    S_PSQ  = 10'b0001000000,
    S_DMUL = 10'b0010000000,
    S_RRAW = 10'b0100000000,
    S_FIN  = 10'b1000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.src    = mau_pkg::SRC_LHS;
    cmd.msel   = mau_pkg::MS_A_B;
    cmd.dest   = mau_pkg::DST_A;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.m_small) begin
            state_next = S_FIN;
          end else if (mau_pkg::func_t'(in_func) == mau_pkg::F_RED) begin
            cmd.start  = 1'b1;
            cmd.src    = mau_pkg::SRC_RAW;
            cmd.dest   = mau_pkg::DST_RAW;
            state_next = S_RRAW;
          end else begin
            cmd.start  = 1'b1;
            state_next = S_RDA;
          end
        end
      end
      S_RDA: begin
        if (sts.done) begin
          cmd.start  = 1'b1;
          cmd.src    = mau_pkg::SRC_RHS;
          cmd.dest   = mau_pkg::DST_B;
          state_next = S_RDB;
        end
      end
      S_RDB: begin
        if (sts.done) begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.func) inside
          mau_pkg::F_MUL: begin
            cmd.start  = 1'b1;
            cmd.src    = mau_pkg::SRC_PROD;
            cmd.dest   = mau_pkg::DST_RES;
            state_next = S_DMUL;
          end
          mau_pkg::F_DIV, mau_pkg::F_POW, mau_pkg::F_INV: begin
            cmd.pow_init = 1'b1;
            state_next   = S_PCHK;
          end
          default: begin
            cmd.simple = 1'b1;
            state_next = S_FIN;
          end
        endcase
      end
      S_PCHK: begin
        if (sts.e_zero) begin
          if (sts.func == mau_pkg::F_DIV) begin
            cmd.start  = 1'b1;
            cmd.src    = mau_pkg::SRC_PROD;
            cmd.msel   = mau_pkg::MS_A_ACC;
            cmd.dest   = mau_pkg::DST_RES;
            state_next = S_DMUL;
          end else begin
            cmd.res_acc = 1'b1;
            state_next  = S_FIN;
          end
        end else if (sts.e_lsb) begin
          cmd.start  = 1'b1;
          cmd.src    = mau_pkg::SRC_PROD;
          cmd.msel   = mau_pkg::MS_ACC_SQ;
          cmd.dest   = mau_pkg::DST_ACC;
          state_next = S_PACC;
        end else begin
          cmd.start   = 1'b1;
          cmd.src     = mau_pkg::SRC_PROD;
          cmd.msel    = mau_pkg::MS_SQ_SQ;
          cmd.dest    = mau_pkg::DST_SQ;
          cmd.e_shift = 1'b1;
          state_next  = S_PSQ;
        end
      end
      S_PACC: begin
        if (sts.done) begin
          cmd.start   = 1'b1;
          cmd.src     = mau_pkg::SRC_PROD;
          cmd.msel    = mau_pkg::MS_SQ_SQ;
          cmd.dest    = mau_pkg::DST_SQ;
          cmd.e_shift = 1'b1;
          state_next  = S_PSQ;
        end
      end
      S_PSQ: begin
        if (sts.done) begin
          state_next = S_PCHK;
        end
      end
      S_DMUL, S_RRAW: begin
        if (sts.done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.out_full || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[hdl/modular_arithmetic_unit_core.sv]
// Top level of the prime-field modular arithmetic unit
//
// Requests arrive on in_ch (valid/ready): func, lhs, rhs, exponent, raw_value.
// Each request gives one result on out_ch: result, equal, less.
// The modulus register is written through cfg_we/cfg_wdata; the user must
// write it only while idle, as the unit itself does not enforce this.
// One request is worked on at a time; in_ch.ready is high only when idle.
// Operand and product remainders come from one bit-serial reducer, and
// products from one 31x31 multiplier feeding it. Pow, inverse and divide
// loop over the exponent, squaring for each bit and multiplying for each set bit.
// A modulus below two skips the work and returns 0.
// The result sits in an output register; while the receiver stalls the
// finished request waits there and the unit holds its next result.
// Reset restores the modulus to 1000000007 and empties the output register.
`timescale 1ns / 1ps
module modular_arithmetic_unit_core #(
  parameter int EXP_BITS = 63
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [30:0]            cfg_wdata,
  mau_in_if.sink                 in_ch,
  mau_out_if.source              out_ch
);

  mau_pkg::cmd_t    cmd;
  mau_pkg::status_t sts;

  // Sequence each request
  mau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_func   (in_ch.func),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Compute and hold results
  mau_datapath #(.EXP_BITS(EXP_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .sts          (sts),
    .in_func      (in_ch.func),
    .in_lhs       (in_ch.lhs),
    .in_rhs       (in_ch.rhs),
    .in_exponent  (in_ch.exponent),
    .in_raw_value (in_ch.raw_value),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_result   (out_ch.result),
    .out_equal    (out_ch.equal),
    .out_less     (out_ch.less)
  );

endmodule

[hdl/mau_checker.sv]
// Port-level checker of the modular arithmetic unit and its bind
`timescale 1ns / 1ps
`include "modular_arithmetic_unit_core_defines.svh"
module mau_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [30:0] result,
  input logic        equal,
  input logic        less
);

  `MAU_ASSERT_RST(a_rst_empty, rst, !out_valid, "output valid after reset")
  `MAU_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second request taken")
  `MAU_ASSERT_IMP(a_flags_excl, out_valid, !(equal && less), "equal and less both set")
  `MAU_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(result), "result dropped")

endmodule

bind modular_arithmetic_unit_core mau_checker u_mau_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .result    (out_ch.result),
  .equal     (out_ch.equal),
  .less      (out_ch.less)
);

[bench/tb_modular_arithmetic_unit_core.sv]
// Self-checking testbench of the modular arithmetic unit core
`timescale 1ns / 1ps
module tb_modular_arithmetic_unit_core;

  localparam int unsigned EXP_W = 63;
  localparam longint unsigned CYCLE_LIMIT = 64'd60_000_000;
  localparam int unsigned RANDOM_PER_MODULUS = 168;
  localparam int unsigned HOLD_CYCLES = 4000;

  typedef struct packed {
    mau_pkg::func_t     func;
    logic [30:0]        lhs;
    logic [30:0]        rhs;
    logic [EXP_W-1:0]   exponent;
    logic signed [63:0] raw_value;
  } request_t;

  typedef struct packed {
    logic [30:0] result;
    logic        equal;
    logic        less;
  } field_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [30:0] cfg_wdata = '0;

  mau_in_if #(.EXP_BITS(EXP_W)) in_ch ();
  mau_out_if out_ch ();

  modular_arithmetic_unit_core #(.EXP_BITS(EXP_W)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #2 clk = ~clk;

  request_t        request_q[$];
  field_result_t   result_q[$];
  logic [30:0]     field_modulus = mau_pkg::MODULUS_RESET;
  int unsigned     mismatches = 0;
  int unsigned     results_seen = 0;
  longint unsigned cycles = 0;

  // Modular helpers on 64-bit words; operands stay below 2^31
  function automatic longint unsigned field_mul(longint unsigned x, longint unsigned y,
                                                longint unsigned m);
    return (x * y) % m;
  endfunction

  function automatic longint unsigned field_pow(longint unsigned base, longint unsigned e,
                                                longint unsigned m);
    longint unsigned acc;
    longint unsigned sq;
    acc = 64'd1 % m;
    sq = base % m;
    for (int i = 0; i < EXP_W; i++) begin
      if (e[i]) acc = field_mul(acc, sq, m);
      sq = field_mul(sq, sq, m);
    end
    return acc;
  endfunction

  function automatic field_result_t predict_result(request_t r, logic [30:0] modulus);
    field_result_t   p;
    longint unsigned m;
    longint unsigned a;
    longint unsigned b;
    longint unsigned mag;
    longint unsigned rem;
    longint unsigned res;
    m = modulus;
    res = 0;
    if (m >= 2) begin
      a = r.lhs % m;
      b = r.rhs % m;
      case (r.func)
        mau_pkg::F_ADD: res = (a + b) % m;
        mau_pkg::F_SUB: res = (a + m - b) % m;
        mau_pkg::F_MUL: res = field_mul(a, b, m);
        mau_pkg::F_DIV: res = field_mul(a, field_pow(b, m - 2, m), m);
        mau_pkg::F_POW: res = field_pow(a, r.exponent, m);
        mau_pkg::F_INV: res = field_pow(a, m - 2, m);
        mau_pkg::F_NEG: res = (a == 0) ? 0 : m - a;
        default: begin
          mag = r.raw_value[63] ? (64'd0 - r.raw_value) : r.raw_value;
          rem = mag % m;
          res = (r.raw_value[63] && rem != 0) ? m - rem : rem;
        end
      endcase
    end
    p.result = res[30:0];
    p.equal = (r.lhs == r.rhs);
    p.less = (r.lhs < r.rhs);
    return p;
  endfunction

  // Operand mostly reduced, sometimes an edge or an unreduced value
  function automatic logic [30:0] rand_operand(logic [30:0] modulus);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return (modulus == 0) ? '0 : modulus - 1;
      2: return 31'($urandom);
      default: return (modulus == 0) ? 31'($urandom) : 31'($urandom % modulus);
    endcase
  endfunction

  function automatic request_t rand_request(logic [30:0] modulus);
    request_t r;
    int unsigned len;
    longint unsigned k;
    r.func = mau_pkg::func_t'($urandom_range(0, 7));
    r.lhs = rand_operand(modulus);
    r.rhs = ($urandom_range(0, 7) == 0) ? r.lhs : rand_operand(modulus);
    // Short exponents keep pow cheap; a quarter use all bits
    len = ($urandom_range(0, 3) == 0) ? EXP_W : $urandom_range(0, 12);
    r.exponent = 63'({$urandom, $urandom});
    if (len < EXP_W) r.exponent &= (63'd1 << len) - 1;
    k = $urandom_range(0, 1000);
    case ($urandom_range(0, 5))
      0: r.raw_value = -(k * modulus);
      1: r.raw_value = k * modulus;
      2: r.raw_value = $urandom_range(0, 1) ? 64'h8000_0000_0000_0000
                                            : 64'h7fff_ffff_ffff_ffff;
      default: r.raw_value = {$urandom, $urandom};
    endcase
    return r;
  endfunction

  function automatic request_t mk(mau_pkg::func_t f, logic [30:0] l, logic [30:0] r,
                                  logic [EXP_W-1:0] e, logic signed [63:0] v);
    request_t q;
    q.func = f;
    q.lhs = l;
    q.rhs = r;
    q.exponent = e;
    q.raw_value = v;
    return q;
  endfunction

  // Sender: bursts of requests with random gaps between them
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.func <= mau_pkg::F_ADD;
      in_ch.lhs <= '0;
      in_ch.rhs <= '0;
      in_ch.exponent <= '0;
      in_ch.raw_value <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        result_q.push_back(predict_result(request_q[0], field_modulus));
        void'(request_q.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40)
                                                 : $urandom_range(0, 4);
          burst_left = $urandom_range(1, 24);
        end
      end else if (!in_ch.valid && gap_left > 0) begin
        gap_left--;
      end
      // Hold an unaccepted request; otherwise offer the next one after the gap
      if (in_ch.valid && !in_ch.ready) begin
        in_ch.valid <= 1'b1;
      end else if (gap_left == 0 && request_q.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.func <= request_q[0].func;
        in_ch.lhs <= request_q[0].lhs;
        in_ch.rhs <= request_q[0].rhs;
        in_ch.exponent <= request_q[0].exponent;
        in_ch.raw_value <= request_q[0].raw_value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern in segments, plus one long hold-off
  int unsigned seg_left = 0;
  int unsigned seg_mode = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && results_seen >= 150) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 2);
        seg_left = $urandom_range(16, 200);
      end else begin
        seg_left--;
      end
      case (seg_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        default: out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", out_ch.result);
      end else begin
        if (out_ch.result !== result_q[0].result || out_ch.equal !== result_q[0].equal ||
            out_ch.less !== result_q[0].less) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp result %0d eq %b lt %b, got result %0d eq %b lt %b",
                     result_q[0].result, result_q[0].equal, result_q[0].less,
                     out_ch.result, out_ch.equal, out_ch.less);
        end
        void'(result_q.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    while (request_q.size() != 0 || result_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_modulus(logic [30:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    field_modulus = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  logic [30:0] moduli[9] = '{31'd2, 31'd3, 31'd7, 31'd2147483647, 31'd65521,
                             31'd1000, 31'd1, 31'd0, 31'd1000000007};

  initial begin
    logic [30:0] m;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    m = mau_pkg::MODULUS_RESET;
    // Directed: extremes, every operation, zero and negative cases
    request_q.push_back(mk(mau_pkg::F_ADD, m - 1, m - 1, '0, '0));
    request_q.push_back(mk(mau_pkg::F_SUB, 31'd0, m - 1, '0, '0));
    request_q.push_back(mk(mau_pkg::F_MUL, m - 1, m - 1, '0, '0));
    request_q.push_back(mk(mau_pkg::F_DIV, 31'd12345, 31'd0, '0, '0));
    request_q.push_back(mk(mau_pkg::F_DIV, m - 1, 31'd2, '0, '0));
    request_q.push_back(mk(mau_pkg::F_POW, 31'd0, 31'd0, '0, '0));
    request_q.push_back(mk(mau_pkg::F_POW, m - 1, 31'd0, '1, '0));
    request_q.push_back(mk(mau_pkg::F_POW, 31'd3, 31'd0, 63'h2aaa_aaaa_aaaa_aaaa, '0));
    request_q.push_back(mk(mau_pkg::F_INV, 31'd0, 31'd0, '0, '0));
    request_q.push_back(mk(mau_pkg::F_INV, 31'd1, 31'd5, '0, '0));
    request_q.push_back(mk(mau_pkg::F_INV, m - 1, 31'd0, '0, '0));
    request_q.push_back(mk(mau_pkg::F_NEG, 31'd0, 31'd0, '0, '0));
    request_q.push_back(mk(mau_pkg::F_NEG, m - 1, 31'd1, '0, '0));
    request_q.push_back(mk(mau_pkg::F_RED, 31'd0, 31'd0, '0, 64'h8000_0000_0000_0000));
    request_q.push_back(mk(mau_pkg::F_RED, 31'd0, 31'd0, '0, 64'h7fff_ffff_ffff_ffff));
    request_q.push_back(mk(mau_pkg::F_RED, 31'd0, 31'd0, '0, -64'sd3000000021));
    request_q.push_back(mk(mau_pkg::F_RED, 31'd0, 31'd0, '0, -64'sd1));
    request_q.push_back(mk(mau_pkg::F_ADD, 31'h7fff_ffff, 31'h7fff_ffff, '0, '0));
    request_q.push_back(mk(mau_pkg::F_MUL, 31'h7fff_ffff, 31'd3, '0, '0));
    request_q.push_back(mk(mau_pkg::F_NEG, m, 31'd0, '0, '0));
    for (int i = 0; i < RANDOM_PER_MODULUS; i++) request_q.push_back(rand_request(m));
    // Random phases, one per modulus setting
    foreach (moduli[p]) begin
      wait_idle();
      write_modulus(moduli[p]);
      @(negedge clk);
      for (int i = 0; i < RANDOM_PER_MODULUS; i++)
        request_q.push_back(rand_request(moduli[p]));
    end
    wait_idle();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
